// ===== rtl/isfp_pkg.sv =====
// Shared constants and types for the IMU serial frame parser.
package isfp_pkg;

   localparam int unsigned WinDepth = 10;
   localparam int unsigned ValWidth = 23;
   localparam int unsigned BrgWidth = 17;

   localparam logic [7:0] HdrByte   = 8'h55;
   localparam logic [7:0] TypeMask  = 8'h50;
   localparam logic [7:0] TypeAccel = 8'h51;
   localparam logic [7:0] TypeGyro  = 8'h52;
   localparam logic [7:0] TypeAngle = 8'h53;
   localparam logic [7:0] TypeMag   = 8'h54;

   localparam logic [7:0] GyroMul  = 8'd125;
   localparam logic [7:0] AngleMul = 8'd45;

   localparam logic [1:0] StCollect = 2'd0;
   localparam logic [1:0] StSlide   = 2'd1;
   localparam logic [1:0] StDecoded = 2'd2;
   localparam logic [1:0] StUnknown = 2'd3;

   localparam logic [3:0] FlagAccel = 4'b0001;
   localparam logic [3:0] FlagGyro  = 4'b0010;
   localparam logic [3:0] FlagAngle = 4'b0100;
   localparam logic [3:0] FlagMag   = 4'b1000;
   localparam logic [3:0] FlagAll   = 4'b1111;

   // window state as seen by the decoder
   typedef struct packed {
      logic                       full;
      logic [7:0]                 sum;
      logic [3:0]                 flags;
      logic [WinDepth-1:0][7:0]   bytes;
   } win_view_type;

   // decoder verdict back to the window
   typedef struct packed {
      logic       frame_ok;
      logic [3:0] flags_next;
   } win_ctl_type;

   typedef struct packed {
      logic                       publish;
      logic [BrgWidth-1:0]        bearing;
      logic signed [ValWidth-1:0] z_value;
      logic signed [ValWidth-1:0] y_value;
      logic signed [ValWidth-1:0] x_value;
      logic [7:0]                 packet_type;
      logic [1:0]                 status;
   } result_type;

endpackage

// ===== rtl/isfp_window.sv =====
// Frame window, running checksum, byte count and collected flags.
module isfp_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  isfp_pkg::win_ctl_type  ctl,
   output isfp_pkg::win_view_type view
);

   logic [isfp_pkg::WinDepth-1:0][7:0] bytes_ff, bytes_in;
   logic [3:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [3:0] flags_ff, flags_in;
   logic       full;

   assign full = (count_ff == 4'(isfp_pkg::WinDepth));

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      flags_in = flags_ff;
      if (accept) begin
         if (!full) begin
            bytes_in[count_ff] = rx_byte;
            count_in = count_ff + 4'd1;
            sum_in   = (count_ff == 4'd0) ? rx_byte : sum_ff + rx_byte;
         end else if (ctl.frame_ok) begin
            count_in = 4'd0;
            flags_in = ctl.flags_next;
         end else begin
            // drop oldest byte, keep sum of the ten held bytes current
            for (int i = 0; i < isfp_pkg::WinDepth - 1; i++) begin
               bytes_in[i] = bytes_ff[i+1];
            end
            bytes_in[isfp_pkg::WinDepth-1] = rx_byte;
            sum_in = sum_ff - bytes_ff[0] + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      sum_ff   <= sum_in;
      if (reset) begin
         count_ff <= 4'd0;
         flags_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   assign view.full  = full;
   assign view.sum   = sum_ff;
   assign view.flags = flags_ff;
   assign view.bytes = bytes_ff;

endmodule

// ===== rtl/isfp_decode.sv =====
// Frame check, raw value scaling, bearing and publish logic.
module isfp_decode (
   input  isfp_pkg::win_view_type view,
   input  logic [7:0]             rx_byte,
   output isfp_pkg::win_ctl_type  ctl,
   output isfp_pkg::result_type   result
);

   logic [7:0]        ptype;
   logic              match;
   logic signed [15:0] raw_x, raw_y, raw_z;
   logic signed [8:0] mul;
   logic [3:0]        set_mask;
   logic [3:0]        flags_or;
   logic              known;
   logic signed [24:0] prod_x, prod_y, prod_z;

   assign ptype = view.bytes[1];
   assign match = view.full && (view.bytes[0] == isfp_pkg::HdrByte)
                  && ((ptype & isfp_pkg::TypeMask) == isfp_pkg::TypeMask)
                  && (view.sum == rx_byte);

   assign raw_x = {view.bytes[3], view.bytes[2]};
   assign raw_y = {view.bytes[5], view.bytes[4]};
   assign raw_z = {view.bytes[7], view.bytes[6]};

   always_comb begin
      unique case (ptype)
         isfp_pkg::TypeAccel: begin
            mul = 9'sd1; set_mask = isfp_pkg::FlagAccel; known = 1'b1;
         end
         isfp_pkg::TypeGyro: begin
            mul = $signed({1'b0, isfp_pkg::GyroMul}); set_mask = isfp_pkg::FlagGyro;
            known = 1'b1;
         end
         isfp_pkg::TypeAngle: begin
            mul = $signed({1'b0, isfp_pkg::AngleMul}); set_mask = isfp_pkg::FlagAngle;
            known = 1'b1;
         end
         isfp_pkg::TypeMag: begin
            mul = 9'sd0; set_mask = isfp_pkg::FlagMag; known = 1'b1;
         end
         default: begin
            mul = 9'sd0; set_mask = 4'd0; known = 1'b0;
         end
      endcase
   end

   assign prod_x = raw_x * mul;
   assign prod_y = raw_y * mul;
   assign prod_z = raw_z * mul;
   assign flags_or = view.flags | set_mask;

   always_comb begin
      result = '0;
      ctl.frame_ok   = match;
      ctl.flags_next = view.flags;
      if (!view.full) begin
         result.status = isfp_pkg::StCollect;
      end else if (!match) begin
         result.status = isfp_pkg::StSlide;
      end else if (!known) begin
         result.status      = isfp_pkg::StUnknown;
         result.packet_type = ptype;
      end else begin
         result.status      = isfp_pkg::StDecoded;
         result.packet_type = ptype;
         result.x_value     = prod_x[isfp_pkg::ValWidth-1:0];
         result.y_value     = prod_y[isfp_pkg::ValWidth-1:0];
         result.z_value     = prod_z[isfp_pkg::ValWidth-1:0];
         if (ptype == isfp_pkg::TypeAngle) begin
            // negative yaw: -r, else 65536 - r
            if (raw_z[15]) begin
               result.bearing = 17'(-$signed({raw_z[15], raw_z}));
            end else begin
               result.bearing = 17'h10000 - {1'b0, raw_z};
            end
         end
         if (flags_or == isfp_pkg::FlagAll) begin
            result.publish = 1'b1;
            ctl.flags_next = 4'd0;
         end else begin
            ctl.flags_next = flags_or;
         end
      end
   end

endmodule

// ===== rtl/imu_serial_frame_parser_top.sv =====
// Top level of the IMU serial frame parser: handshake and result register.
//
//   channel | dir | tdata                                   | tuser
//   req     | in  | rx_byte[7:0]                            | -
//   rsp     | out | x[22:0] y[45:23] z[68:46] bearing[85:69] | status[1:0]
//           |     | publish[86], zero pad [87]              | packet_type[9:2]
//
// One request per cycle unless rsp stalls; each yields a response in the next cycle.
// State (window, count, running checksum, flags) updates at request accept.
// The result register holds a pending response until rsp_tready; req_tready follows it.
// Reset clears the byte count, the collected flags and the response valid.
module imu_serial_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // x_value, y_value, z_value, bearing, publish, pad
   output logic [9:0]  rsp_tuser    // status, packet_type
);

   isfp_pkg::win_view_type view;
   isfp_pkg::win_ctl_type  ctl;
   isfp_pkg::result_type   result;
   isfp_pkg::result_type   rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   isfp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .ctl     (ctl),
      .view    (view)
   );

   isfp_decode u_decode (
      .view    (view),
      .rx_byte (req_tdata),
      .ctl     (ctl),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.publish, rsp_ff.bearing,
                        rsp_ff.z_value, rsp_ff.y_value, rsp_ff.x_value};
   assign rsp_tuser  = {rsp_ff.packet_type, rsp_ff.status};

endmodule
